@@ rtl/feedback_delay_echo_4ch_top_assert.svh @@
// Assertion macros for the echo block.
`ifndef FEEDBACK_DELAY_ECHO_4CH_TOP_ASSERT_SVH
`define FEEDBACK_DELAY_ECHO_4CH_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define FDE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fde: same-cycle check failed");
`define FDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fde: next-cycle check failed");
`else
`define FDE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FDE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/fde_pkg.sv @@
`default_nettype none

package fde_pkg;

    localparam int FRAME_SAMPLES = 160;
    localparam int MAX_DELAY     = 8192;
    localparam int CHANNELS      = 4;

    localparam int SAMPLE_W   = 32;
    localparam int COEF_W     = 16;
    localparam int INT_W      = 48;
    localparam int FRAC_W     = 8;
    localparam int Q_SHIFT    = 7;
    localparam int PROD_W     = COEF_W + INT_W;
    localparam int SHR_W      = PROD_W - Q_SHIFT;
    localparam int ACC_W      = SHR_W + 1;
    localparam int FRAMES_W   = 10;
    localparam int POS_W      = $clog2(MAX_DELAY);
    localparam int LEN_W      = $clog2(MAX_DELAY + 1);
    localparam int LPROD_W    = FRAMES_W + $clog2(FRAME_SAMPLES + 1);
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W     = CH_W + POS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;
    localparam int QT_W       = INT_W - FRAC_W + 1;

    localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE,
        REG_DELAY_FRAMES,
        REG_FEEDBACK_G,
        REG_GAIN_A,
        REG_POLE_B
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MA,
        S_SY,
        S_MG,
        S_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [LEN_W-1:0]         len;
        logic signed [COEF_W-1:0] g;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic                     clr;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [INT_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // saturate a wide sum to the internal 48-bit range
    function automatic logic signed [INT_W-1:0] sat_int(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-INT_W:0] hi;
        hi = v[ACC_W-1:INT_W-1];
        if ((&hi) || !(|hi)) begin
            return v[INT_W-1:0];
        end
        return v[ACC_W-1] ? INT_MIN : INT_MAX;
    endfunction

    // drop the fraction toward zero, then clamp to the sample range
    function automatic logic signed [SAMPLE_W-1:0] to_sample(input logic signed [INT_W-1:0] y);
        logic signed [INT_W:0]  t;
        logic signed [QT_W-1:0] q;
        logic [QT_W-SAMPLE_W:0] hi;
        t  = (INT_W+1)'(y) + (y[INT_W-1] ? (INT_W+1)'((1 << FRAC_W) - 1) : '0);
        q  = t[INT_W:FRAC_W];
        hi = q[QT_W-1:SAMPLE_W-1];
        if ((&hi) || !(|hi)) begin
            return q[SAMPLE_W-1:0];
        end
        return q[QT_W-1] ? SMP_MIN : SMP_MAX;
    endfunction

endpackage

`default_nettype wire

@@ rtl/fde_if.sv @@
`default_nettype none

interface fde_in_if;
    import fde_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] in_ch0;
    logic signed [SAMPLE_W-1:0] in_ch1;
    logic signed [SAMPLE_W-1:0] in_ch2;
    logic signed [SAMPLE_W-1:0] in_ch3;
    modport source (output valid, in_ch0, in_ch1, in_ch2, in_ch3, input ready);
    modport sink (input valid, in_ch0, in_ch1, in_ch2, in_ch3, output ready);
endinterface

interface fde_out_if;
    import fde_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_ch0;
    logic signed [SAMPLE_W-1:0] out_ch1;
    logic signed [SAMPLE_W-1:0] out_ch2;
    logic signed [SAMPLE_W-1:0] out_ch3;
    modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, input ready);
    modport sink (input valid, out_ch0, out_ch1, out_ch2, out_ch3, output ready);
endinterface

`default_nettype wire

@@ rtl/fde_ram.sv @@
`default_nettype none

module fde_ram #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 48
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire [ADDR_W-1:0] i_waddr,
    input  wire [DATA_W-1:0] i_wdata,
    input  wire [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/fde_cfg.sv @@
`default_nettype none

module fde_cfg (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [fde_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [fde_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output fde_pkg::t_cfg                    o_cfg
);
    import fde_pkg::*;

    logic                     r_enable, n_enable;
    logic [FRAMES_W-1:0]      r_frames, n_frames;
    logic signed [COEF_W-1:0] r_g, n_g;
    logic signed [COEF_W-1:0] r_a, n_a;
    logic signed [COEF_W-1:0] r_b, n_b;
    logic [LEN_W-1:0]         r_len, n_len;
    logic                     r_clr;
    logic [LPROD_W-1:0]       raw_len;

    always_comb begin
        n_enable = r_enable;
        n_frames = r_frames;
        n_g      = r_g;
        n_a      = r_a;
        n_b      = r_b;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ENABLE:       n_enable = i_cfg_data[0];
                REG_DELAY_FRAMES: n_frames = i_cfg_data[FRAMES_W-1:0];
                REG_FEEDBACK_G:   n_g      = i_cfg_data;
                REG_GAIN_A:       n_a      = i_cfg_data;
                REG_POLE_B:       n_b      = i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective length: frames times frame size, clamped to the store depth, zero while disabled
    always_comb begin
        raw_len = LPROD_W'(n_frames) * LPROD_W'(FRAME_SAMPLES);
        if (!n_enable) begin
            n_len = '0;
        end else if (raw_len > LPROD_W'(MAX_DELAY)) begin
            n_len = LEN_W'(MAX_DELAY);
        end else begin
            n_len = raw_len[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_frames <= '0;
            r_g      <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_len    <= '0;
            r_clr    <= 1'b0;
        end else begin
            r_enable <= n_enable;
            r_frames <= n_frames;
            r_g      <= n_g;
            r_a      <= n_a;
            r_b      <= n_b;
            r_len    <= n_len;
            r_clr    <= (n_len != r_len);
        end
    end

    assign o_cfg.len = r_len;
    assign o_cfg.g   = r_g;
    assign o_cfg.a   = r_a;
    assign o_cfg.b   = r_b;
    assign o_cfg.clr = r_clr;

endmodule

`default_nettype wire

@@ rtl/fde_core.sv @@
`default_nettype none

module fde_core (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire fde_pkg::t_cfg          i_cfg,
    input  wire [fde_pkg::INT_W-1:0]    i_rd_data,
    output fde_pkg::t_mem_req           o_mem,
    fde_in_if.sink                      i_src,
    fde_out_if.source                   o_res
);
    import fde_pkg::*;

    t_state r_state, n_state;

    logic [CH_W-1:0]           r_ch;
    logic [POS_W-1:0]          r_pos;
    logic                      r_filled;
    logic                      r_ovalid;
    logic signed [INT_W-1:0]   r_prev [CHANNELS];
    logic signed [SAMPLE_W-1:0] r_x   [CHANNELS];
    logic signed [SAMPLE_W-1:0] r_q   [CHANNELS];
    logic signed [SAMPLE_W-1:0] r_out [CHANNELS];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SHR_W-1:0]   r_acc;
    logic signed [INT_W-1:0]   r_y;

    logic signed [SAMPLE_W-1:0] x_in [CHANNELS];
    logic signed [COEF_W-1:0]  mul_c;
    logic signed [INT_W-1:0]   mul_d;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [INT_W-1:0]   dly;
    logic signed [SHR_W-1:0]   prod_shr;
    logic signed [ACC_W-1:0]   y_sum;
    logic signed [ACC_W-1:0]   v_diff;
    logic signed [INT_W-1:0]   v_new;
    logic                      out_load;
    logic [LEN_W-1:0]          pos_inc;

    assign x_in[0] = i_src.in_ch0;
    assign x_in[1] = i_src.in_ch1;
    assign x_in[2] = i_src.in_ch2;
    assign x_in[3] = i_src.in_ch3;

    // entries past the pointer read as zero until the first wrap
    assign dly      = r_filled ? $signed(i_rd_data) : '0;
    assign mul_p    = PROD_W'(mul_c) * PROD_W'(mul_d);
    assign prod_shr = r_prod[PROD_W-1:Q_SHIFT];
    assign y_sum    = ACC_W'(r_acc) + ACC_W'(prod_shr);
    assign v_diff   = ACC_W'($signed({r_x[r_ch], {FRAC_W{1'b0}}})) - ACC_W'(prod_shr);
    assign v_new    = sat_int(v_diff);
    assign out_load = (r_state == S_DONE) && (!r_ovalid || o_res.ready);
    assign pos_inc  = LEN_W'(r_pos) + LEN_W'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_src.valid) begin
                    n_state = (i_cfg.len == '0) ? S_DONE : S_RD;
                end
            end
            S_RD: n_state = S_MA;
            S_MA: n_state = S_SY;
            S_SY: n_state = S_MG;
            S_MG: n_state = S_WR;
            S_WR: n_state = (r_ch == CH_W'(CHANNELS - 1)) ? S_DONE : S_RD;
            S_DONE: begin
                if (!r_ovalid || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_src.ready = 1'b0;
        mul_c       = '0;
        mul_d       = '0;
        o_mem.we    = 1'b0;
        o_mem.waddr = {r_ch, r_pos};
        o_mem.wdata = v_new;
        o_mem.raddr = {r_ch, r_pos};
        unique case (r_state)
            S_IDLE: i_src.ready = 1'b1;
            S_RD: begin
                mul_c = i_cfg.b;
                mul_d = r_prev[r_ch];
            end
            S_MA: begin
                mul_c = i_cfg.a;
                mul_d = dly;
            end
            S_MG: begin
                mul_c = i_cfg.g;
                mul_d = r_y;
            end
            S_WR: o_mem.we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ch     <= '0;
            r_pos    <= '0;
            r_filled <= 1'b0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_prev[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_src.valid && i_src.ready) begin
                r_ch <= '0;
            end
            if (r_state == S_WR) begin
                r_prev[r_ch] <= r_y;
                r_ch         <= r_ch + CH_W'(1);
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
                if (i_cfg.len != '0) begin
                    if (pos_inc >= i_cfg.len) begin
                        r_pos    <= '0;
                        r_filled <= 1'b1;
                    end else begin
                        r_pos <= pos_inc[POS_W-1:0];
                    end
                end
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            // length change: restart pointer and recursion
            if (i_cfg.clr) begin
                r_pos    <= '0;
                r_filled <= 1'b0;
                for (int k = 0; k < CHANNELS; k++) begin
                    r_prev[k] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_src.valid && i_src.ready) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_x[k] <= x_in[k];
                r_q[k] <= x_in[k];
            end
        end
        case (r_state)
            S_RD: r_prod <= mul_p;
            S_MA: begin
                r_acc  <= prod_shr;
                r_prod <= mul_p;
            end
            S_SY: r_y    <= sat_int(y_sum);
            S_MG: r_prod <= mul_p;
            S_WR: r_q[r_ch] <= to_sample(r_y);
            default: ;
        endcase
        if (out_load) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_out[k] <= r_q[k];
            end
        end
    end

    assign o_res.valid   = r_ovalid;
    assign o_res.out_ch0 = r_out[0];
    assign o_res.out_ch1 = r_out[1];
    assign o_res.out_ch2 = r_out[2];
    assign o_res.out_ch3 = r_out[3];

endmodule

`default_nettype wire

@@ rtl/feedback_delay_echo_4ch_top.sv @@
// Four-channel feedback delay echo.
// With the echo on, each item takes five steps per channel through the shared multiplier
// and the single read port and single write port of the delay store; in bypass it goes
// straight to the output register. A new item is taken only once the last one is done.
// Reset clears the control registers, pointer and recursion state; the store needs no
// clearing pass, since entries ahead of the pointer read as zero until its first wrap.
`default_nettype none

`include "feedback_delay_echo_4ch_top_assert.svh"

module feedback_delay_echo_4ch_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [fde_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [fde_pkg::CFG_DATA_W-1:0] i_cfg_data,
    fde_in_if.sink                        i_src,
    fde_out_if.source                     o_res
);
    import fde_pkg::*;

    t_cfg             cfg;
    t_mem_req         mem_req;
    logic [INT_W-1:0] rd_data;

    fde_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    fde_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_rd_data (rd_data),
        .o_mem     (mem_req),
        .i_src     (i_src),
        .o_res     (o_res)
    );

    fde_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (INT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (rd_data)
    );

    `FDE_ASSERT_IMPLY(a_wr_in_range, i_clk, i_rst_n, mem_req.we, LEN_W'(mem_req.waddr[POS_W-1:0]) < cfg.len)
    `FDE_ASSERT_IMPLY(a_bypass_no_wr, i_clk, i_rst_n, cfg.len == '0, !mem_req.we)
    `FDE_ASSERT_NEXT(a_clr_after_wr, i_clk, i_rst_n, !i_cfg_we, !cfg.clr)

endmodule

`default_nettype wire

@@ sim/feedback_delay_echo_4ch_top_tb.sv @@
module feedback_delay_echo_4ch_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fde_pkg::*;

    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] t_quad;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int IDLE_MAX      = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int MAX_REPORTS   = 40;
    localparam int FRAMES_W      = 10;
    localparam int FRAMES_MAX    = (1 << FRAMES_W) - 1;
    localparam int FRAMES_CLAMP  = MAX_DELAY / FRAME_SAMPLES + 1;
    localparam int SPARE_IDX_LO  = int'(REG_POLE_B) + 1;
    localparam int SPARE_IDX_HI  = (1 << CFG_IDX_W) - 1;
    localparam logic [COEF_W-1:0] Q7_ONE = COEF_W'(128);
    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fde_in_if  src_if ();
    fde_out_if res_if ();

    feedback_delay_echo_4ch_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_src      (src_if),
        .o_res      (res_if)
    );

    // mirror of the block's registers and echo state
    bit          cfg_en;
    int unsigned cfg_frames;
    longint      coef_g, coef_a, coef_b;
    int          echo_len;
    int          tap_pos;
    longint      echo_line [CHANNELS*MAX_DELAY];
    longint      last_y [CHANNELS];

    t_quad echo_expect [$];

    int  errors;
    int  n_sent, n_echo, n_checked, n_cfg_writes, n_settings;
    bit  src_quiet, res_quiet, hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic longint clamp48(input longint v);
        if (v > longint'(INT_MAX)) return longint'(INT_MAX);
        if (v < longint'(INT_MIN)) return longint'(INT_MIN);
        return v;
    endfunction

    function automatic void clear_echo_state();
        int i;
        for (i = 0; i < CHANNELS*MAX_DELAY; i++) echo_line[i] = 0;
        for (i = 0; i < CHANNELS; i++) last_y[i] = 0;
        tap_pos = 0;
    endfunction

    function automatic void track_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        int new_len;
        case (idx)
            REG_ENABLE:       cfg_en = data[0];
            REG_DELAY_FRAMES: cfg_frames = data[FRAMES_W-1:0];
            REG_FEEDBACK_G:   coef_g = longint'($signed(data));
            REG_GAIN_A:       coef_a = longint'($signed(data));
            REG_POLE_B:       coef_b = longint'($signed(data));
            default:          return;
        endcase
        new_len = 0;
        if (cfg_en) begin
            new_len = cfg_frames * FRAME_SAMPLES;
            if (new_len > MAX_DELAY) new_len = MAX_DELAY;
        end
        // any change of the effective length starts the echo from silence
        if (new_len != echo_len) begin
            echo_len = new_len;
            clear_echo_state();
        end
    endfunction

    function automatic t_quad echo_predict(input t_quad x_in);
        t_quad  y_out;
        longint x, y, v, q;
        int     k, idx;
        y_out = x_in;
        if (echo_len != 0) begin
            n_echo++;
            for (k = 0; k < CHANNELS; k++) begin
                x   = longint'($signed(x_in[k]));
                idx = k*MAX_DELAY + tap_pos;
                y   = clamp48(((coef_b * last_y[k]) >>> 7) + ((coef_a * echo_line[idx]) >>> 7));
                v   = clamp48(x * 256 - ((coef_g * y) >>> 7));
                echo_line[idx] = v;
                last_y[k]      = y;
                // drop the fraction toward zero, then clamp to the sample range
                q = (y >= 0) ? (y >>> 8) : -((-y) >>> 8);
                if (q > longint'(SMP_MAX)) q = longint'(SMP_MAX);
                if (q < longint'(SMP_MIN)) q = longint'(SMP_MIN);
                y_out[k] = q[SAMPLE_W-1:0];
            end
            tap_pos = (tap_pos + 1 >= echo_len) ? 0 : tap_pos + 1;
        end
        return y_out;
    endfunction

    function automatic t_quad quad(input logic [SAMPLE_W-1:0] c0, c1, c2, c3);
        return {c3, c2, c1, c0};
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return SAMPLE_W'($urandom_range(4096) - 2048);
            3:       return SAMPLE_W'($urandom_range(1 << 20) - (1 << 19));
            default: return $urandom();
        endcase
    endfunction

    function automatic t_quad pick_quad();
        return quad(pick_sample(), pick_sample(), pick_sample(), pick_sample());
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(5))
            0:       return COEF_W'($urandom());
            1:       return COEF_W'($urandom_range(320) - 160);
            2:       return $urandom_range(1) ? COEF_MAX : COEF_MIN;
            3:       return $urandom_range(1) ? Q7_ONE : -Q7_ONE;
            4:       return '0;
            default: return COEF_W'($urandom_range(2*Q7_ONE) - Q7_ONE);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        track_reg_write(idx, data);
        n_cfg_writes++;
    endtask

    task automatic apply_cfg(input bit en, input int frames,
                             input logic [COEF_W-1:0] g, a, b);
        write_reg(REG_ENABLE, CFG_DATA_W'(en));
        write_reg(REG_DELAY_FRAMES, CFG_DATA_W'(frames));
        write_reg(REG_FEEDBACK_G, g);
        write_reg(REG_GAIN_A, a);
        write_reg(REG_POLE_B, b);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // valid is left high after a transfer so back-to-back items never toggle it
    task automatic send_frame(input t_quad f);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(IDLE_MAX);
        if (gap > 0) begin
            src_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        src_if.valid  <= 1'b1;
        src_if.in_ch0 <= f[0];
        src_if.in_ch1 <= f[1];
        src_if.in_ch2 <= f[2];
        src_if.in_ch3 <= f[3];
        @(posedge i_clk);
        while (!src_if.ready) @(posedge i_clk);
        echo_expect.push_back(echo_predict(f));
        n_sent++;
    endtask

    task automatic drain_results();
        src_if.valid <= 1'b0;
        while (echo_expect.size() != 0) @(posedge i_clk);
    endtask

    initial begin : receiver
        int stall;
        res_if.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = res_quiet ? 0 : $urandom_range(IDLE_MAX);
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_quad got, want;
        int    k;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = {res_if.out_ch3, res_if.out_ch2, res_if.out_ch1, res_if.out_ch0};
            if (echo_expect.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
                want = echo_expect.pop_front();
                n_checked++;
                for (k = 0; k < CHANNELS; k++) begin
                    if (got[k] !== want[k]) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: ch%0d expected %0d actual %0d", $time, k,
                                     $signed(want[k]), $signed(got[k]));
                    end
                end
            end
        end
    end

    task automatic test_bypass();
        send_frame(quad(SMP_MAX, SMP_MIN, '0, '1));
        send_frame(quad(SMP_MIN, '1, SMP_MAX, '0));
        send_frame(quad('0, SMP_MAX, '1, SMP_MIN));
        send_frame(pick_quad());
        drain_results();
    endtask

    task automatic test_zero_length();
        apply_cfg(1'b1, 0, COEF_MAX, COEF_MIN, COEF_MAX);
        send_frame(quad(SMP_MAX, SMP_MAX, SMP_MIN, SMP_MIN));
        send_frame(quad('1, '0, '1, '0));
        send_frame(pick_quad());
        drain_results();
    endtask

    task automatic test_length_clamp();
        apply_cfg(1'b1, FRAMES_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
        send_frame(quad(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN));
        send_frame(quad(SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX));
        send_frame(pick_quad());
        send_frame(pick_quad());
        drain_results();
        // same clamped length: state carries on
        apply_cfg(1'b1, FRAMES_CLAMP, COEF_MAX, COEF_MAX, COEF_MAX);
        send_frame(pick_quad());
        send_frame(pick_quad());
        drain_results();
        apply_cfg(1'b0, FRAMES_CLAMP, '0, '0, '0);
    endtask

    task automatic test_spare_index();
        int i;
        for (i = SPARE_IDX_LO; i <= SPARE_IDX_HI; i++) write_reg(CFG_IDX_W'(i), '1);
        i_cfg_we <= 1'b0;
        send_frame(pick_quad());
        send_frame(pick_quad());
        drain_results();
        apply_cfg(1'b1, 1, Q7_ONE, Q7_ONE, Q7_ONE / 2);
        for (i = SPARE_IDX_LO; i <= SPARE_IDX_HI; i++) write_reg(CFG_IDX_W'(i), '0);
        i_cfg_we <= 1'b0;
        repeat (4) send_frame(pick_quad());
        drain_results();
    endtask

    task automatic test_output_backpressure();
        apply_cfg(1'b1, 1, Q7_ONE / 2, Q7_ONE, Q7_ONE / 4);
        src_quiet = 1'b1;
        hold_req  = 1'b1;
        repeat (40) send_frame(pick_quad());
        drain_results();
        src_quiet = 1'b0;
    endtask

    task automatic test_random_settings();
        int left, chunk, kind, frames;
        bit en;
        left = RANDOM_ITEMS;
        while (left > 0) begin
            kind   = $urandom_range(9);
            en     = cfg_en;
            frames = cfg_frames;
            if (kind >= 4 && kind <= 6) begin
                en     = 1'b1;
                frames = $urandom_range(2, 1);
            end else if (kind == 7) begin
                en     = 1'b1;
                frames = $urandom_range(FRAMES_MAX, 3);
            end else if (kind == 8) begin
                en     = 1'b0;
                frames = $urandom_range(FRAMES_MAX);
            end else if (kind == 9) begin
                en     = 1'b1;
                frames = 0;
            end
            // otherwise keep the length and change only the gains
            apply_cfg(en, frames, pick_coef(), pick_coef(), pick_coef());
            src_quiet = ($urandom_range(3) == 0);
            res_quiet = ($urandom_range(3) == 0);
            chunk = $urandom_range(300, 40);
            if (chunk > left) chunk = left;
            repeat (chunk) send_frame(pick_quad());
            drain_results();
            left -= chunk;
        end
        src_quiet = 1'b0;
        res_quiet = 1'b0;
    endtask

    initial begin
        errors        = 0;
        cfg_en        = 1'b0;
        cfg_frames    = 0;
        coef_g        = 0;
        coef_a        = 0;
        coef_b        = 0;
        echo_len      = 0;
        clear_echo_state();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        src_if.valid  = 1'b0;
        src_if.in_ch0 = '0;
        src_if.in_ch1 = '0;
        src_if.in_ch2 = '0;
        src_if.in_ch3 = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_bypass();
        test_zero_length();
        test_length_clamp();
        test_spare_index();
        test_output_backpressure();
        test_random_settings();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (echo_expect.size() != 0) errors++;

        $display("summary: %0d sample sets sent, %0d through the echo path, %0d results checked",
                 n_sent, n_echo, n_checked);
        $display("summary: %0d register writes over %0d settings, %0d mismatches",
                 n_cfg_writes, n_settings, errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
